[design/pixel_hue_rotation_assert.svh]
// ---------------------------------------------------------------------------
// pixel_hue_rotation assertion macros
// Shared property forms for the hue rotation checker.
// ---------------------------------------------------------------------------
`ifndef PIXEL_HUE_ROTATION_ASSERT_SVH
`define PIXEL_HUE_ROTATION_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define PHR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pixel_hue_rotation: property failed");

// next-cycle implication, disabled while reset is high
`define PHR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pixel_hue_rotation: property failed");

// next-cycle implication that also holds across reset
`define PHR_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("pixel_hue_rotation: property failed");

`endif

[design/phr_pkg.sv]
// ---------------------------------------------------------------------------
// phr_pkg
// Constants, types and helper functions of the pixel hue rotation block.
// ---------------------------------------------------------------------------
package phr_pkg;

   localparam int HUE_TURN   = 5760;
   localparam int HUE_SECTOR = 960;
   localparam int ONE12      = 4096;
   localparam int NUM_STAGES = 10;

   localparam int CHAN_W  = 8;
   localparam int HUE_W   = 13;
   localparam int FRAC_W  = 13;
   localparam int QUO_W   = 13;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   // floor(x / 15) == (x * DIV15_MUL) >> DIV15_SHIFT for x below 4096
   localparam int DIV15_MUL   = 17477;
   localparam int DIV15_SHIFT = 18;

   // floor(x / 255) == (x * DIV255_MUL) >> DIV255_SHIFT for x below 4387
   localparam int DIV255_MUL   = 4113;
   localparam int DIV255_SHIFT = 20;

   // register index, taken from csr_paddr[2]
   localparam logic REG_HUE_SHIFT = 1'b0;

   typedef struct packed {
      logic [HUE_W-1:0] base;
      logic             neg;
      logic             grey;
      logic             mx_zero;
   } hue_ctl_type;

   // one restoring division step: shift the remainder, subtract if it fits
   function automatic logic [CHAN_W:0] div_step(input logic [CHAN_W-1:0] rem,
                                                 input logic [CHAN_W-1:0] den);
      logic [CHAN_W:0] t;
      logic [CHAN_W:0] d;
      t = {rem, 1'b0};
      d = {1'b0, den};
      if (t >= d) begin
         return {1'b1, CHAN_W'(t - d)};
      end
      return {1'b0, t[CHAN_W-1:0]};
   endfunction

endpackage

[design/phr_div.sv]
// ---------------------------------------------------------------------------
// phr_div
// Three-stage restoring divider giving round(num * 4096 / den), num <= den.
// ---------------------------------------------------------------------------
module phr_div import phr_pkg::*; (
   input  logic              clock,
   input  logic [2:0]        adv,
   input  logic [CHAN_W-1:0] num,
   input  logic [CHAN_W-1:0] den,
   output logic [QUO_W-1:0]  quo
);

   logic [CHAN_W-1:0] rem_a_ff, rem_a_in, den_a_ff;
   logic [4:0]        quo_a_ff, quo_a_in;
   logic [CHAN_W-1:0] rem_b_ff, rem_b_in, den_b_ff;
   logic [8:0]        quo_b_ff, quo_b_in;
   logic [QUO_W-1:0]  quo_c_ff, quo_c_in;
   logic [CHAN_W:0]   step_a, step_b, step_c;
   logic [CHAN_W-1:0] rem_c;
   logic [13:0]       q14;
   logic [14:0]       q_round;

   // integer bit and four fraction bits
   always_comb begin
      step_a = '0;
      quo_a_in = '0;
      rem_a_in = num;
      if (num >= den) begin
         quo_a_in[4] = 1'b1;
         rem_a_in = num - den;
      end
      for (int i = 3; i >= 0; i--) begin
         step_a = div_step(rem_a_in, den);
         quo_a_in[i] = step_a[CHAN_W];
         rem_a_in = step_a[CHAN_W-1:0];
      end
   end

   always_comb begin
      step_b = '0;
      rem_b_in = rem_a_ff;
      quo_b_in = {quo_a_ff, 4'b0};
      for (int i = 3; i >= 0; i--) begin
         step_b = div_step(rem_b_in, den_a_ff);
         quo_b_in[i] = step_b[CHAN_W];
         rem_b_in = step_b[CHAN_W-1:0];
      end
   end

   // last five bits, then round half up by dropping the extra bit
   always_comb begin
      step_c = '0;
      rem_c = rem_b_ff;
      q14 = {quo_b_ff, 5'b0};
      for (int i = 4; i >= 0; i--) begin
         step_c = div_step(rem_c, den_b_ff);
         q14[i] = step_c[CHAN_W];
         rem_c = step_c[CHAN_W-1:0];
      end
      q_round = {1'b0, q14} + 15'd1;
      quo_c_in = q_round[13:1];
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         rem_a_ff <= rem_a_in;
         quo_a_ff <= quo_a_in;
         den_a_ff <= den;
      end
      if (adv[1]) begin
         rem_b_ff <= rem_b_in;
         quo_b_ff <= quo_b_in;
         den_b_ff <= den_a_ff;
      end
      if (adv[2]) begin
         quo_c_ff <= quo_c_in;
      end
   end

   assign quo = quo_c_ff;

endmodule

[design/pixel_hue_rotation.sv]
// ---------------------------------------------------------------------------
// pixel_hue_rotation
// RGBA pixel hue rotation through HSV, ten-stage pipeline.
// ---------------------------------------------------------------------------
// Pixels enter on the req_ stream (tdata: red, green, blue, alpha from bit 0)
// and leave on the rsp_ stream in the same packing, one result word per input
// word, in order. Alpha is carried through untouched.
// The hue offset is set through the csr_ port (register 0, hue_shift, in
// sixteenths of a degree); write it only while the pipeline is empty.
// One word enters every cycle while no stage is stalled; the hue and
// saturation dividers run as three pipelined stages of an integer compare
// and thirteen restoring steps, the value comes from a reciprocal
// multiplication, and the back conversion uses one multiplier stage, with a
// 20 x 13 product for the 1 - S term and 20 x 22 products for the others.
// Each stage advances when it is empty or the stage after it advances, so
// a stalled receiver first lets bubbles close up and then drops req_tready.
// Reset empties the pipeline and clears hue_shift to zero.
module pixel_hue_rotation import phr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // req_tdata: red_in, green_in, blue_in, alpha_in (from bit 0)
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,
   // rsp_tdata: red_out, green_out, blue_out, alpha_out (from bit 0)
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   logic [HUE_W-1:0]      shift_ff;
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] en;
   logic [CHAN_W-1:0]     alpha_ff [NUM_STAGES];

   // stage 0
   logic [CHAN_W-1:0] red, green, blue, mx, mn, chan_c;
   logic [CHAN_W-1:0] hx0_ff, d0_ff, mx0_ff;
   hue_ctl_type       ctl_in;
   hue_ctl_type       ctl_ff [4];

   // dividers
   logic [QUO_W-1:0]  q_hue, q_sat, q_val;

   // value
   logic [HUE_W-1:0]  val_y;
   logic [25:0]       val_prod;
   logic [QUO_W-1:0]  val1_in, val1_ff, val2_ff, val3_ff;

   // stage 4
   logic [10:0]       qh;
   logic [16:0]       q15;
   logic [HUE_W:0]    hue, hsum4_in, hsum4_ff;
   logic [FRAC_W-1:0] s4_in, s4_ff, v4_ff;

   // stage 5
   logic [HUE_W-1:0]  hm;
   logic [2:0]        sec5_in, sec5_ff;
   logic [9:0]        rem5_ff;
   logic [HUE_W-1:0]  rem5_full;
   logic [FRAC_W-1:0] s5_ff;
   logic [20:0]       a5_full;
   logic [19:0]       a5_ff;

   // stage 6
   logic [22:0]       sr_y, sr_z;
   logic [9:0]        rem_inv;
   logic [FRAC_W-1:0] tx6_ff;
   logic [21:0]       ty6_ff, tz6_ff;
   logic [19:0]       a6_ff, vv_sum;
   logic [CHAN_W-1:0] vv6_ff, vv7_ff, vv8_ff;
   logic [2:0]        sec6_ff, sec7_ff, sec8_ff;

   // stage 7 and 8
   logic [32:0]       px7_ff;
   logic [41:0]       py7_ff, pz7_ff;
   logic [33:0]       px_sum;
   logic [42:0]       py_sum, pz_sum;
   logic [CHAN_W-1:0] vx8_ff;
   logic [11:0]       my8_ff, mz8_ff;

   // stage 9
   logic [26:0]       vy_prod, vz_prod;
   logic [CHAN_W-1:0] vy, vz;
   logic [CHAN_W-1:0] red9_in, green9_in, blue9_in;
   logic [CHAN_W-1:0] red9_ff, green9_ff, blue9_ff;

   // ------------------------------------------------------------------
   // configuration
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_HUE_SHIFT) ?
                       {{(CSR_DW-HUE_W){1'b0}}, shift_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == REG_HUE_SHIFT) begin
         shift_ff <= csr_pwdata[HUE_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // pipeline control
   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];
   assign rsp_tdata  = {alpha_ff[NUM_STAGES-1], blue9_ff, green9_ff, red9_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         alpha_ff[0] <= req_tdata[31:24];
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (en[i]) begin
            alpha_ff[i] <= alpha_ff[i-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 0: max, min and hue sector
   always_comb begin
      red   = req_tdata[7:0];
      green = req_tdata[15:8];
      blue  = req_tdata[23:16];
      mx = red;
      mn = red;
      if (green > mx) mx = green;
      if (blue > mx)  mx = blue;
      if (green < mn) mn = green;
      if (blue < mn)  mn = blue;
      ctl_in.grey    = (mx == mn);
      ctl_in.mx_zero = (mx == '0);
      if (red == mx) begin
         if (green == mn) begin
            ctl_in.base = HUE_W'(5 * HUE_SECTOR);
            ctl_in.neg  = 1'b0;
            chan_c      = blue;
         end else begin
            ctl_in.base = HUE_W'(HUE_SECTOR);
            ctl_in.neg  = 1'b1;
            chan_c      = green;
         end
      end else if (green == mx) begin
         if (blue == mn) begin
            ctl_in.base = HUE_W'(HUE_SECTOR);
            ctl_in.neg  = 1'b0;
            chan_c      = red;
         end else begin
            ctl_in.base = HUE_W'(3 * HUE_SECTOR);
            ctl_in.neg  = 1'b1;
            chan_c      = blue;
         end
      end else if (red == mn) begin
         ctl_in.base = HUE_W'(3 * HUE_SECTOR);
         ctl_in.neg  = 1'b0;
         chan_c      = green;
      end else begin
         ctl_in.base = HUE_W'(5 * HUE_SECTOR);
         ctl_in.neg  = 1'b1;
         chan_c      = red;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         hx0_ff    <= mx - chan_c;
         d0_ff     <= mx - mn;
         mx0_ff    <= mx;
         ctl_ff[0] <= ctl_in;
      end
      for (int i = 1; i < 4; i++) begin
         if (en[i]) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // stages 1 to 3: hue quotient and saturation
   phr_div u_div_hue (
      .clock (clock),
      .adv   (en[3:1]),
      .num   (hx0_ff),
      .den   (d0_ff),
      .quo   (q_hue)
   );

   phr_div u_div_sat (
      .clock (clock),
      .adv   (en[3:1]),
      .num   (d0_ff),
      .den   (mx0_ff),
      .quo   (q_sat)
   );

   // value: 16 max + round(16 max / 255), then hold in step with the dividers
   always_comb begin
      val_y    = HUE_W'({mx0_ff, 4'b0}) + HUE_W'(127);
      val_prod = 26'(val_y) * 26'(DIV255_MUL);
      val1_in  = QUO_W'({mx0_ff, 4'b0}) +
                 QUO_W'(val_prod[DIV255_SHIFT+4:DIV255_SHIFT]);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         val1_ff <= val1_in;
      end
      if (en[2]) begin
         val2_ff <= val1_ff;
      end
      if (en[3]) begin
         val3_ff <= val2_ff;
      end
   end

   assign q_val = val3_ff;

   // ------------------------------------------------------------------
   // stage 4: hue in sixteenths of a degree plus the offset
   always_comb begin
      q15 = {q_hue, 4'b0} - {4'b0, q_hue} + 17'd32;
      qh  = q15[16:6];
      if (ctl_ff[3].neg) begin
         hue = {1'b0, ctl_ff[3].base} - {3'b0, qh};
      end else begin
         hue = {1'b0, ctl_ff[3].base} + {3'b0, qh};
      end
      if (hue > (HUE_W+1)'(HUE_TURN)) begin
         hue = (HUE_W+1)'(HUE_TURN);
      end
      if (ctl_ff[3].grey) begin
         hue = '0;
      end
      hsum4_in = hue + {1'b0, shift_ff};
      s4_in = ctl_ff[3].mx_zero ? '0 : q_sat;
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         hsum4_ff <= hsum4_in;
         s4_ff    <= s4_in;
         v4_ff    <= q_val;
      end
   end

   // ------------------------------------------------------------------
   // stage 5: wrap at a full turn, split into sector and remainder
   always_comb begin
      if (hsum4_ff >= (HUE_W+1)'(2 * HUE_TURN)) begin
         hm = HUE_W'(hsum4_ff - (HUE_W+1)'(2 * HUE_TURN));
      end else if (hsum4_ff >= (HUE_W+1)'(HUE_TURN)) begin
         hm = HUE_W'(hsum4_ff - (HUE_W+1)'(HUE_TURN));
      end else begin
         hm = hsum4_ff[HUE_W-1:0];
      end
      sec5_in = '0;
      for (int k = 1; k < 6; k++) begin
         if (hm >= HUE_W'(k * HUE_SECTOR)) begin
            sec5_in = 3'(k);
         end
      end
      rem5_full = hm - HUE_W'(HUE_W'(sec5_in) * HUE_W'(HUE_SECTOR));
      a5_full = {v4_ff, 8'b0} - {8'b0, v4_ff};
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         sec5_ff <= sec5_in;
         rem5_ff <= rem5_full[9:0];
         s5_ff   <= s4_ff;
         a5_ff   <= a5_full[19:0];
      end
   end

   // ------------------------------------------------------------------
   // stage 6: the 1 - S, 1 - S F and 1 - S (1 - F) terms
   always_comb begin
      rem_inv = 10'(HUE_SECTOR) - rem5_ff;
      sr_y = 23'(s5_ff) * 23'(rem5_ff);
      sr_z = 23'(s5_ff) * 23'(rem_inv);
      vv_sum = a5_ff + 20'd2048;
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         tx6_ff  <= FRAC_W'(ONE12) - s5_ff;
         ty6_ff  <= 22'(23'(ONE12 * HUE_SECTOR) - sr_y);
         tz6_ff  <= 22'(23'(ONE12 * HUE_SECTOR) - sr_z);
         a6_ff   <= a5_ff;
         vv6_ff  <= vv_sum[19:12];
         sec6_ff <= sec5_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 7: products
   always_ff @(posedge clock) begin
      if (en[7]) begin
         px7_ff  <= 33'(a6_ff) * 33'(tx6_ff);
         py7_ff  <= 42'(a6_ff) * 42'(ty6_ff);
         pz7_ff  <= 42'(a6_ff) * 42'(tz6_ff);
         vv7_ff  <= vv6_ff;
         sec7_ff <= sec6_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 8: round and scale down by powers of two
   always_comb begin
      px_sum = {1'b0, px7_ff} + 34'(1 << 23);
      py_sum = {1'b0, py7_ff} + (43'(HUE_SECTOR / 2) << 24);
      pz_sum = {1'b0, pz7_ff} + (43'(HUE_SECTOR / 2) << 24);
   end

   always_ff @(posedge clock) begin
      if (en[8]) begin
         vx8_ff  <= px_sum[31:24];
         my8_ff  <= py_sum[41:30];
         mz8_ff  <= pz_sum[41:30];
         vv8_ff  <= vv7_ff;
         sec8_ff <= sec7_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 9: divide by fifteen and place by sector
   always_comb begin
      vy_prod = 27'(my8_ff) * 27'(DIV15_MUL);
      vz_prod = 27'(mz8_ff) * 27'(DIV15_MUL);
      vy = vy_prod[DIV15_SHIFT+7:DIV15_SHIFT];
      vz = vz_prod[DIV15_SHIFT+7:DIV15_SHIFT];
      case (sec8_ff)
         3'd0: begin
            red9_in = vv8_ff; green9_in = vz;     blue9_in = vx8_ff;
         end
         3'd1: begin
            red9_in = vy;     green9_in = vv8_ff; blue9_in = vx8_ff;
         end
         3'd2: begin
            red9_in = vx8_ff; green9_in = vv8_ff; blue9_in = vz;
         end
         3'd3: begin
            red9_in = vx8_ff; green9_in = vy;     blue9_in = vv8_ff;
         end
         3'd4: begin
            red9_in = vz;     green9_in = vx8_ff; blue9_in = vv8_ff;
         end
         default: begin
            red9_in = vv8_ff; green9_in = vx8_ff; blue9_in = vy;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[9]) begin
         red9_ff   <= red9_in;
         green9_ff <= green9_in;
         blue9_ff  <= blue9_in;
      end
   end

endmodule

[design/phr_checker.sv]
// ---------------------------------------------------------------------------
// phr_checker
// Port-level checks of the pixel hue rotation block, bound to the top level.
// ---------------------------------------------------------------------------
`include "pixel_hue_rotation_assert.svh"

module phr_checker import phr_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [31:0]       rsp_tdata,
   input logic              csr_psel,
   input logic              csr_penable,
   input logic              csr_pwrite,
   input logic [CSR_AW-1:0] csr_paddr,
   input logic [CSR_DW-1:0] csr_pwdata,
   input logic [CSR_DW-1:0] csr_prdata,
   input logic              csr_pready
);

   logic shift_write;
   assign shift_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                        csr_paddr[2] == REG_HUE_SHIFT;

   `PHR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `PHR_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_tvalid)
   `PHR_ASSERT_SAME(a_full_only, clock, reset, !req_tready, rsp_tvalid && !rsp_tready)
   `PHR_ASSERT_NEXT(a_shift_read, clock, reset, shift_write, csr_paddr[2] != REG_HUE_SHIFT || csr_prdata[HUE_W-1:0] == $past(csr_pwdata[HUE_W-1:0]))

endmodule

bind pixel_hue_rotation phr_checker u_phr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata),
   .csr_pready  (csr_pready)
);
